/* sv/usan_pkg.sv */
package usan_pkg;

  // Longest accepted sequence and the bytes held while it is pending
  localparam int unsigned MaxSeqLen  = 6;
  localparam int unsigned HoldDepth  = MaxSeqLen - 1;
  localparam int unsigned QueueDepth = 4;

  localparam int unsigned CntW    = $clog2(MaxSeqLen + 1);
  localparam int unsigned ResIdxW = $clog2(MaxSeqLen);
  localparam int unsigned QPtrW   = $clog2(QueueDepth);
  localparam int unsigned QCntW   = $clog2(QueueDepth + 1);

  // Byte classes
  localparam logic [7:0] AsciiLim = 8'h80;
  localparam logic [7:0] ContBase = 8'h80;
  localparam logic [7:0] ContMask = 8'h3F;
  localparam logic [7:0] LeadMin  = 8'hC2;
  localparam logic [7:0] LeadBad  = 8'hFE;
  localparam logic [7:0] Lead3    = 8'hE0;
  localparam logic [7:0] Lead4    = 8'hF0;
  localparam logic [7:0] Lead5    = 8'hF8;
  localparam logic [7:0] Lead6    = 8'hFC;
  localparam logic [7:0] ReplByte = 8'hFF;
  localparam logic [7:0] EndByte  = 8'h00;

  // One queued request: the results one input item causes
  typedef struct packed {
    logic [MaxSeqLen-1:0][7:0] bytes;
    logic [MaxSeqLen-1:0]      starts;
    logic [CntW-1:0]           count;
    logic                      end_flag;
  } entry_t;

  // Outcome of a byte seen with no sequence pending
  typedef struct packed {
    logic            emit;
    logic [7:0]      value;
    logic            lead;
    logic [CntW-1:0] len;
  } fresh_t;

  function automatic fresh_t classify_fresh(logic [7:0] b);
    fresh_t          r;
    logic [CntW-1:0] len;
    len     = CntW'(6);
    r.emit  = 1'b1;
    r.value = ReplByte;
    r.lead  = 1'b0;
    r.len   = '0;
    if (b < Lead3) begin
      len = CntW'(2);
    end else if (b < Lead4) begin
      len = CntW'(3);
    end else if (b < Lead5) begin
      len = CntW'(4);
    end else if (b < Lead6) begin
      len = CntW'(5);
    end
    if (b < AsciiLim) begin
      r.value = b;
    end else if (b < LeadMin || b >= LeadBad) begin
      r.value = ReplByte;
    end else if (len > CntW'(MaxSeqLen)) begin
      r.value = ReplByte;
    end else begin
      r.emit = 1'b0;
      r.lead = 1'b1;
      r.len  = len;
    end
    return r;
  endfunction

endpackage

/* sv/utf8_sequence_sanitizer.sv */
// Channel  Direction  Handshake               Payload
// in       in         in_valid_i / in_stall_o   mode_i, in_byte_i
// out      out        out_valid_o / out_stall_i out_byte_o, char_start_o, end_marker_o, last_o
//
// Takes one input byte per cycle while the 4-entry request queue has room.
// Emits one result per cycle while a request is queued and out_stall_i allows; an item with k results yields k outputs.
// An accepted item that yields results is written into the queue; the output register then
// loads them from the queue head once earlier requests have left and out_stall_i allows.
// rst_ni clears held-sequence state, queue pointers and output valid at once.
// in_stall_o is the queue-full flag; out_stall_i only holds the output register and,
// through the queue filling up, reaches the input side later.
module utf8_sequence_sanitizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       char_start_o,
  output logic       end_marker_o,
  output logic       last_o
);
  import usan_pkg::*;

  logic   q_push, q_full, q_valid, q_pop;
  entry_t q_in, q_head;

  usan_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .in_byte_i   (in_byte_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_entry_o(q_in)
  );

  usan_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_entry_i(q_in),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .pop_i       (q_pop)
  );

  usan_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_valid),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .char_start_o(char_start_o),
    .end_marker_o(end_marker_o),
    .last_o      (last_o)
  );

  // Queue never written while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("request queue overflow");

  // Queue never popped while empty
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("request queue underflow");

  // End marker closes its item and carries a zero byte
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && end_marker_o) |-> (last_o && out_byte_o == EndByte && !char_start_o))
    else $error("malformed end marker");

  // End-of-data request always reaches the queue
  a_end_pushed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && mode_i) |-> q_push)
    else $error("end of data not queued");

endmodule

/* sv/usan_front.sv */
module usan_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            mode_i,
  input  logic [7:0]      in_byte_i,
  input  logic            q_full_i,
  output logic            push_o,
  output usan_pkg::entry_t push_entry_o
);
  import usan_pkg::*;

  logic [7:0]      held_q [HoldDepth];
  logic [CntW-1:0] held_cnt_q, held_cnt_d;
  logic [CntW-1:0] exp_len_q, exp_len_d;

  fresh_t          fr;
  logic            accept, is_cont, pending, flush, complete, extend, fresh_path;
  logic            tail_en, tail_start;
  logic [7:0]      tail_byte;
  logic [CntW-1:0] count;
  entry_t          entry;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Classify the byte against the pending sequence
  always_comb begin
    fr         = classify_fresh(in_byte_i);
    is_cont    = (in_byte_i ^ ContBase) <= ContMask;
    pending    = held_cnt_q != '0;
    flush      = mode_i || (pending && !is_cont);
    complete   = !mode_i && pending && is_cont && ((held_cnt_q + CntW'(1)) >= exp_len_q);
    extend     = !mode_i && pending && is_cont && !complete;
    fresh_path = !mode_i && (!pending || !is_cont);
    tail_en    = mode_i || complete || (fresh_path && fr.emit);
    tail_start = fresh_path;
    if (mode_i) begin
      tail_byte = EndByte;
    end else if (complete) begin
      tail_byte = in_byte_i;
    end else begin
      tail_byte = fr.value;
    end
    count = held_cnt_q + CntW'(tail_en);
  end

  // Build the request: held bytes (or their replacements), then at most one tail result
  always_comb begin
    entry          = '0;
    entry.count    = count;
    entry.end_flag = mode_i;
    for (int i = 0; i < int'(MaxSeqLen); i++) begin
      if (i < int'(HoldDepth)) begin
        entry.bytes[i] = flush ? ReplByte : held_q[i];
      end
      entry.starts[i] = (i == 0);
      if (tail_en && CntW'(i) == held_cnt_q) begin
        entry.bytes[i]  = tail_byte;
        entry.starts[i] = tail_start;
      end
    end
  end

  assign push_o       = accept && !extend && (count != '0);
  assign push_entry_o = entry;

  // Next pending-sequence state
  always_comb begin
    held_cnt_d = held_cnt_q;
    exp_len_d  = exp_len_q;
    if (accept) begin
      if (extend) begin
        held_cnt_d = held_cnt_q + CntW'(1);
      end else if (fresh_path && fr.lead) begin
        held_cnt_d = CntW'(1);
        exp_len_d  = fr.len;
      end else begin
        held_cnt_d = '0;
        exp_len_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= '0;
      exp_len_q  <= '0;
    end else begin
      held_cnt_q <= held_cnt_d;
      exp_len_q  <= exp_len_d;
    end
  end

  // Held bytes: payload only
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < int'(HoldDepth); i++) begin
      if (accept && extend && CntW'(i) == held_cnt_q) begin
        held_q[i] <= in_byte_i;
      end else if (accept && fresh_path && fr.lead && i == 0) begin
        held_q[i] <= in_byte_i;
      end
    end
  end

endmodule

/* sv/usan_queue.sv */
module usan_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  usan_pkg::entry_t push_entry_i,
  output logic             full_o,
  output logic             valid_o,
  output usan_pkg::entry_t head_o,
  input  logic             pop_i
);
  import usan_pkg::*;

  entry_t           mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == QCntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

/* sv/usan_back.sv */
module usan_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  usan_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             char_start_o,
  output logic             end_marker_o,
  output logic             last_o
);
  import usan_pkg::*;

  logic [ResIdxW-1:0] idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         byte_q;
  logic               start_q, end_q, last_q;
  logic               load, at_last;

  // Walk the head request one result per cycle while the output is not stalled
  assign load    = head_valid_i && (!out_valid_q || !out_stall_i);
  assign at_last = CntW'(idx_q) == (head_i.count - CntW'(1));
  assign pop_o   = load && at_last;

  always_comb begin
    idx_d = idx_q;
    if (pop_o) begin
      idx_d = '0;
    end else if (load) begin
      idx_d = idx_q + ResIdxW'(1);
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= head_i.bytes[idx_q];
      start_q <= head_i.starts[idx_q];
      end_q   <= head_i.end_flag && at_last;
      last_q  <= at_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = byte_q;
  assign char_start_o = start_q;
  assign end_marker_o = end_q;
  assign last_o       = last_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

import usan_pkg::*;

// Request codes on mode_i
localparam logic ModeData = 1'b0;
localparam logic ModeEnd  = 1'b1;

typedef struct packed {
  logic [7:0] value;
  logic       start;
  logic       endm;
  logic       last;
} san_result_t;

// Tracks the pending UTF-8 sequence and the results each request should cause
class san_scoreboard;
  san_result_t expected_q[$];
  logic [7:0]  held_seq[HoldDepth];
  int unsigned held_num;
  int unsigned seq_len;
  int unsigned errors;

  function new();
    held_num = 0;
    seq_len  = 0;
    errors   = 0;
  endfunction

  function void emit(logic [7:0] value, logic start, logic endm);
    san_result_t r;
    r.value = value;
    r.start = start;
    r.endm  = endm;
    r.last  = 1'b0;
    expected_q.push_back(r);
  endfunction

  // Held bytes become replacement bytes; only the first marks a start
  function void flush_held();
    for (int unsigned i = 0; i < held_num && i < HoldDepth; i++) begin
      emit(ReplByte, i == 0, 1'b0);
    end
    held_num = 0;
    seq_len  = 0;
  endfunction

  // Byte seen with nothing pending: pass, replace, or open a sequence
  function void take_fresh(logic [7:0] b);
    int unsigned len;
    if (b < AsciiLim) begin
      emit(b, 1'b1, 1'b0);
    end else if (b < LeadMin || b >= LeadBad) begin
      emit(ReplByte, 1'b1, 1'b0);
    end else begin
      len = (b < Lead3) ? 2 : (b < Lead4) ? 3 : (b < Lead5) ? 4 : (b < Lead6) ? 5 : 6;
      if (len > MaxSeqLen) begin
        emit(ReplByte, 1'b1, 1'b0);
      end else begin
        held_seq[0] = b;
        held_num    = 1;
        seq_len     = len;
      end
    end
  endfunction

  function void note_request(logic mode, logic [7:0] b);
    int unsigned first;
    san_result_t tail;
    first = expected_q.size();
    if (mode == ModeEnd) begin
      flush_held();
      emit(EndByte, 1'b0, 1'b1);
    end else if (seq_len == 0 || held_num == 0) begin
      held_num = 0;
      seq_len  = 0;
      take_fresh(b);
    end else if ((b ^ ContBase) <= ContMask) begin
      if (held_num + 1 >= seq_len) begin
        // sequence complete: release it whole
        for (int unsigned i = 0; i < held_num && i < HoldDepth; i++) begin
          emit(held_seq[i], i == 0, 1'b0);
        end
        emit(b, 1'b0, 1'b0);
        held_num = 0;
        seq_len  = 0;
      end else if (held_num < HoldDepth) begin
        held_seq[held_num] = b;
        held_num++;
      end
    end else begin
      // broken sequence: flush, then the byte starts over
      flush_held();
      take_fresh(b);
    end
    if (expected_q.size() > first) begin
      tail = expected_q.pop_back();
      tail.last = 1'b1;
      expected_q.push_back(tail);
    end
  endfunction

  function void cmp_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endfunction

  function void check_result(san_result_t got);
    san_result_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual byte %h start %b end %b last %b",
               $time, got.value, got.start, got.endm, got.last);
      return;
    end
    want = expected_q.pop_front();
    cmp_field("out_byte", want.value, got.value);
    cmp_field("char_start", 8'(want.start), 8'(got.start));
    cmp_field("end_marker", 8'(want.endm), 8'(got.endm));
    cmp_field("last", 8'(want.last), 8'(got.last));
  endfunction
endclass

module tb_top;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       mode_i = ModeData;
  logic [7:0] in_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       char_start_o;
  logic       end_marker_o;
  logic       last_o;

  san_scoreboard sb;
  bit            gaps_on = 1'b1;
  bit            hold_req = 1'b0;
  int unsigned   items_sent = 0;
  logic [8:0]    dir_q[$];

  utf8_sequence_sanitizer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .char_start_o(char_start_o),
    .end_marker_o(end_marker_o),
    .last_o      (last_o)
  );

  always #6 clk_i = ~clk_i;

  // Offer one request, with an optional gap first; returns on a falling edge
  task automatic send_item(input logic mode, input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    in_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(mode, b);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] lead_byte(int unsigned len);
    case (len)
      2:       return 8'($urandom_range(8'hC2, 8'hDF));
      3:       return 8'($urandom_range(8'hE0, 8'hEF));
      4:       return 8'($urandom_range(8'hF0, 8'hF7));
      5:       return 8'($urandom_range(8'hF8, 8'hFB));
      6:       return 8'($urandom_range(8'hFC, 8'hFD));
      default: return 8'($urandom_range(8'h00, 8'h7F));
    endcase
  endfunction

  // One random group: whole characters half the time, else broken ones, end requests and noise
  task automatic send_group();
    int unsigned pick;
    int unsigned len;
    int unsigned conts;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      len = $urandom_range(1, MaxSeqLen);
      send_item(ModeData, lead_byte(len));
      repeat (len - 1) send_item(ModeData, 8'($urandom_range(8'h80, 8'hBF)));
    end else if (pick < 66) begin
      // truncated sequence cut by a non-continuation byte or end of data
      len   = $urandom_range(2, MaxSeqLen);
      conts = $urandom_range(0, len - 2);
      send_item(ModeData, lead_byte(len));
      repeat (conts) send_item(ModeData, 8'($urandom_range(8'h80, 8'hBF)));
      if ($urandom_range(0, 3) == 0) begin
        send_item(ModeEnd, 8'($urandom));
      end else begin
        b = 8'($urandom_range(0, 191));
        if (b >= 8'h80) b = b + 8'h40;
        send_item(ModeData, b);
      end
    end else if (pick < 78) begin
      send_item(ModeData, 8'($urandom));
    end else if (pick < 85) begin
      send_item(ModeEnd, 8'($urandom));
    end else begin
      b = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'hFE, 8'hFF))
                                      : 8'($urandom_range(8'h80, 8'hC1));
      send_item(ModeData, b);
    end
  endtask

  // Main flow: reset, directed requests, random groups, drain
  initial begin
    bit held_once;
    bit drained_once;
    sb = new();
    held_once    = 1'b0;
    drained_once = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ASCII limits, stray bytes, shortest and longest sequences,
    // broken sequences, end of data with and without held bytes
    dir_q = '{9'h000, 9'h07F, 9'h080, 9'h0C1, 9'h0FE, 9'h0FF,
              9'h0C2, 9'h080,
              9'h0FD, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF, 9'h0BF,
              9'h0E0, 9'h080, 9'h041,
              9'h0F0, 9'h090, 9'h0C3, 9'h1AA,
              9'h155};
    foreach (dir_q[i]) send_item(dir_q[i][8], dir_q[i][7:0]);

    while (items_sent < 310) begin
      if (!held_once && items_sent >= 100) begin
        // receiver holds off while requests keep coming
        held_once = 1'b1;
        hold_req  = 1'b1;
      end
      if (!drained_once && items_sent >= 190) begin
        drained_once = 1'b1;
        in_valid_i <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk_i);
      end
      if (items_sent >= 250) gaps_on = 1'b0;
      send_group();
    end
    in_valid_i <= 1'b0;

    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Output-side stall: random bursts, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (250) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result('{out_byte_o, char_start_o, end_marker_o, last_o});
    end
  end

  initial begin
    #4_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
